### hw/rtl/alb_pkg.sv
// Package for the alarm LED blink controller.
// Register indexes, reset values, blink flag positions and shared struct types.
// No dependencies.
package alb_pkg;

   localparam int CSR_INDEX_WIDTH = 8;
   localparam int CSR_DATA_WIDTH  = 8;
   localparam int COUNT_WIDTH     = 8;

   localparam logic [CSR_INDEX_WIDTH-1:0] REG_SHORT_TERMINAL  = 8'd0;
   localparam logic [CSR_INDEX_WIDTH-1:0] REG_MID_TERMINAL    = 8'd1;
   localparam logic [CSR_INDEX_WIDTH-1:0] REG_LONG_TERMINAL   = 8'd2;
   localparam logic [CSR_INDEX_WIDTH-1:0] REG_SAMPLE_TERMINAL = 8'd3;

   localparam logic [COUNT_WIDTH-1:0] SHORT_TERMINAL_RESET  = 8'd15;
   localparam logic [COUNT_WIDTH-1:0] MID_TERMINAL_RESET    = 8'd50;
   localparam logic [COUNT_WIDTH-1:0] LONG_TERMINAL_RESET   = 8'd100;
   localparam logic [COUNT_WIDTH-1:0] SAMPLE_TERMINAL_RESET = 8'd3;

   localparam int NUM_FLAGS = 5;
   localparam int FLAG_ST_MID   = 0;
   localparam int FLAG_ST_SHORT = 1;
   localparam int FLAG_PW_LONG  = 2;
   localparam int FLAG_PW_MID   = 3;
   localparam int FLAG_PW_SHORT = 4;

   localparam int REGION_FAST = 0;
   localparam int REGION_MID  = 1;

   typedef struct packed {
      logic [COUNT_WIDTH-1:0] short_terminal;
      logic [COUNT_WIDTH-1:0] mid_terminal;
      logic [COUNT_WIDTH-1:0] long_terminal;
      logic [COUNT_WIDTH-1:0] sample_terminal;
   } cfg_type;

   typedef struct packed {
      logic [2:0] zone_alarm;
      logic       motor_slow;
      logic       laser_dead;
      logic       over_temp;
      logic       window_dirty;
   } alarm_type;

   typedef struct packed {
      logic power_write;
      logic power_level;
      logic status_write;
      logic status_level;
      logic region_changed;
      logic laser_alarm_write;
   } led_rsp_type;

endpackage

### hw/rtl/alb_csr.sv
// Configuration registers of the alarm LED blink controller.
// Depends on alb_pkg.
module alb_csr
   import alb_pkg::*;
(
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       csr_valid,
   output logic                       csr_ready,
   input  logic [CSR_INDEX_WIDTH-1:0] csr_index,
   input  logic [CSR_DATA_WIDTH-1:0]  csr_data,
   output cfg_type                    cfg
);

   cfg_type cfg_ff;

   assign csr_ready = 1'b1;
   assign cfg       = cfg_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.short_terminal  <= SHORT_TERMINAL_RESET;
         cfg_ff.mid_terminal    <= MID_TERMINAL_RESET;
         cfg_ff.long_terminal   <= LONG_TERMINAL_RESET;
         cfg_ff.sample_terminal <= SAMPLE_TERMINAL_RESET;
      end else if (csr_valid) begin
         case (csr_index)
            REG_SHORT_TERMINAL:  cfg_ff.short_terminal  <= csr_data;
            REG_MID_TERMINAL:    cfg_ff.mid_terminal    <= csr_data;
            REG_LONG_TERMINAL:   cfg_ff.long_terminal   <= csr_data;
            REG_SAMPLE_TERMINAL: cfg_ff.sample_terminal <= csr_data;
            default: ;
         endcase
      end
   end

endmodule

### hw/rtl/alb_tick_core.sv
// Per-tick state of the controller: blink counters, sticky flags, LED states
// and switch sampling. Result is combinational from the held item and state.
// Depends on alb_pkg.
module alb_tick_core
   import alb_pkg::*;
#(
   parameter int SWITCH_WIDTH = 8
)
(
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    step,
   input  cfg_type                 cfg,
   input  alarm_type               alarm,
   input  logic [SWITCH_WIDTH-1:0] switch_sample,
   output led_rsp_type             rsp,
   output logic [SWITCH_WIDTH-1:0] region_value
);

   localparam int NUM_CNT = 6;
   localparam int CNT_ST_MID   = 0;
   localparam int CNT_ST_SHORT = 1;
   localparam int CNT_PW_LONG  = 2;
   localparam int CNT_PW_MID   = 3;
   localparam int CNT_PW_SHORT = 4;
   localparam int CNT_SAMPLE   = 5;

   logic [COUNT_WIDTH-1:0]  cnt_ff [NUM_CNT];
   logic [COUNT_WIDTH-1:0]  cnt_in [NUM_CNT];
   logic [COUNT_WIDTH-1:0]  term   [NUM_CNT];
   logic [NUM_CNT-1:0]      wrap;
   logic [NUM_FLAGS-1:0]    flags_ff, flags_in, flags_set;
   logic                    power_state_ff, power_state_in;
   logic                    status_state_ff, status_state_in;
   logic [SWITCH_WIDTH-1:0] prev_sample_ff, prev_sample_in;
   logic                    pw_toggle, st_toggle;
   logic                    status_steady, status_blink;

   assign term[CNT_ST_MID]   = cfg.mid_terminal;
   assign term[CNT_ST_SHORT] = cfg.short_terminal;
   assign term[CNT_PW_LONG]  = cfg.long_terminal;
   assign term[CNT_PW_MID]   = cfg.mid_terminal;
   assign term[CNT_PW_SHORT] = cfg.short_terminal;
   assign term[CNT_SAMPLE]   = cfg.sample_terminal;

   always_comb begin
      for (int i = 0; i < NUM_CNT; i++) begin
         wrap[i]   = (cnt_ff[i] == term[i]);
         cnt_in[i] = wrap[i] ? '0 : cnt_ff[i] + 1'b1;
      end
   end

   always_comb begin
      flags_set                = flags_ff;
      flags_set[FLAG_ST_MID]   = flags_ff[FLAG_ST_MID]   | wrap[CNT_ST_MID];
      flags_set[FLAG_ST_SHORT] = flags_ff[FLAG_ST_SHORT] | wrap[CNT_ST_SHORT];
      flags_set[FLAG_PW_LONG]  = flags_ff[FLAG_PW_LONG]  | wrap[CNT_PW_LONG];
      flags_set[FLAG_PW_MID]   = flags_ff[FLAG_PW_MID]   | wrap[CNT_PW_MID];
      flags_set[FLAG_PW_SHORT] = flags_ff[FLAG_PW_SHORT] | wrap[CNT_PW_SHORT];
   end

   always_comb begin
      flags_in        = flags_set;
      power_state_in  = power_state_ff;
      status_state_in = status_state_ff;
      pw_toggle       = 1'b0;
      st_toggle       = 1'b0;
      rsp             = '0;
      status_steady   = alarm.motor_slow | alarm.laser_dead;
      status_blink    = alarm.window_dirty | alarm.over_temp;

      // power LED: highest-priority region bit picks the flag
      if (alarm.zone_alarm != '0) begin
         if (alarm.zone_alarm[REGION_FAST]) begin
            pw_toggle = flags_set[FLAG_PW_SHORT];
            flags_in[FLAG_PW_SHORT] = 1'b0;
         end else if (alarm.zone_alarm[REGION_MID]) begin
            pw_toggle = flags_set[FLAG_PW_MID];
            flags_in[FLAG_PW_MID] = 1'b0;
         end else begin
            pw_toggle = flags_set[FLAG_PW_LONG];
            flags_in[FLAG_PW_LONG] = 1'b0;
         end
         if (pw_toggle) begin
            power_state_in  = ~power_state_ff;
            rsp.power_write = 1'b1;
            rsp.power_level = ~power_state_ff;
         end
      end else begin
         rsp.power_write = 1'b1;
         rsp.power_level = 1'b1;
      end

      // status LED
      if (status_steady) begin
         rsp.status_write      = 1'b1;
         rsp.status_level      = 1'b1;
         rsp.laser_alarm_write = 1'b1;
      end else if (status_blink) begin
         if (alarm.window_dirty) begin
            st_toggle = flags_set[FLAG_ST_MID];
            flags_in[FLAG_ST_MID] = 1'b0;
         end else begin
            st_toggle = flags_set[FLAG_ST_SHORT];
            flags_in[FLAG_ST_SHORT] = 1'b0;
         end
         if (st_toggle) begin
            status_state_in  = ~status_state_ff;
            rsp.status_write = 1'b1;
            rsp.status_level = ~status_state_ff;
         end
         rsp.laser_alarm_write = 1'b1;
      end

      // switch sampling
      rsp.region_changed = wrap[CNT_SAMPLE] && (switch_sample != prev_sample_ff);
      prev_sample_in     = wrap[CNT_SAMPLE] ? switch_sample : prev_sample_ff;
   end

   assign region_value = rsp.region_changed ? switch_sample : '0;

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < NUM_CNT; i++) begin
            cnt_ff[i] <= '0;
         end
         flags_ff        <= '0;
         power_state_ff  <= 1'b0;
         status_state_ff <= 1'b0;
         prev_sample_ff  <= '0;
      end else if (step) begin
         for (int i = 0; i < NUM_CNT; i++) begin
            cnt_ff[i] <= cnt_in[i];
         end
         flags_ff        <= flags_in;
         power_state_ff  <= power_state_in;
         status_state_ff <= status_state_in;
         prev_sample_ff  <= prev_sample_in;
      end
   end

endmodule

### hw/rtl/alarm_led_blink_controller_top.sv
// An accepted item passes through the input register, then the result register;
// one item per cycle while rsp_ready does not hold the result register.
// Back-pressure on rsp_ready stalls both registers; req_ready follows it.
// Synchronous active-high reset clears counters, flags, LED states, the last
// switch sample and both valid bits; terminals return to 15, 50, 100 and 3.
module alarm_led_blink_controller_top
   import alb_pkg::*;
#(
   parameter int SWITCH_WIDTH = 8
)
(
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       csr_valid,
   output logic                       csr_ready,
   input  logic [CSR_INDEX_WIDTH-1:0] csr_index,
   input  logic [CSR_DATA_WIDTH-1:0]  csr_data,
   input  logic                       req_valid,
   output logic                       req_ready,
   input  logic [2:0]                 req_zone_alarm,
   input  logic                       req_motor_slow,
   input  logic                       req_laser_dead,
   input  logic                       req_over_temp,
   input  logic                       req_window_dirty,
   input  logic [SWITCH_WIDTH-1:0]    req_switch_sample,
   output logic                       rsp_valid,
   input  logic                       rsp_ready,
   output logic                       rsp_power_write,
   output logic                       rsp_power_level,
   output logic                       rsp_status_write,
   output logic                       rsp_status_level,
   output logic                       rsp_region_changed,
   output logic [SWITCH_WIDTH-1:0]    rsp_region_value,
   output logic                       rsp_laser_alarm_write
);

   cfg_type                 cfg;
   alarm_type               alarm_ff;
   logic [SWITCH_WIDTH-1:0] switch_ff;
   logic                    in_valid_ff;
   logic                    advance;
   logic                    step;
   led_rsp_type             core_rsp;
   logic [SWITCH_WIDTH-1:0] core_value;
   led_rsp_type             rsp_ff;
   logic [SWITCH_WIDTH-1:0] rsp_value_ff;
   logic                    rsp_valid_ff;

   alb_csr u_csr (
      .clock     (clock),
      .reset     (reset),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_index (csr_index),
      .csr_data  (csr_data),
      .cfg       (cfg)
   );

   assign advance   = !rsp_valid_ff || rsp_ready;
   assign req_ready = !in_valid_ff || advance;
   assign step      = in_valid_ff && advance;

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else if (req_ready) begin
         in_valid_ff <= req_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (req_valid && req_ready) begin
         alarm_ff.zone_alarm   <= req_zone_alarm;
         alarm_ff.motor_slow   <= req_motor_slow;
         alarm_ff.laser_dead   <= req_laser_dead;
         alarm_ff.over_temp    <= req_over_temp;
         alarm_ff.window_dirty <= req_window_dirty;
         switch_ff             <= req_switch_sample;
      end
   end

   alb_tick_core #(
      .SWITCH_WIDTH (SWITCH_WIDTH)
   ) u_core (
      .clock         (clock),
      .reset         (reset),
      .step          (step),
      .cfg           (cfg),
      .alarm         (alarm_ff),
      .switch_sample (switch_ff),
      .rsp           (core_rsp),
      .region_value  (core_value)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (advance) begin
         rsp_valid_ff <= in_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (step) begin
         rsp_ff       <= core_rsp;
         rsp_value_ff <= core_value;
      end
   end

   assign rsp_valid             = rsp_valid_ff;
   assign rsp_power_write       = rsp_ff.power_write;
   assign rsp_power_level       = rsp_ff.power_level;
   assign rsp_status_write      = rsp_ff.status_write;
   assign rsp_status_level      = rsp_ff.status_level;
   assign rsp_region_changed    = rsp_ff.region_changed;
   assign rsp_region_value      = rsp_value_ff;
   assign rsp_laser_alarm_write = rsp_ff.laser_alarm_write;

endmodule

### hw/rtl/alb_checker.sv
// Port-level checks for the alarm LED blink controller, bound to the top level.
// Depends on alarm_led_blink_controller_top.
module alb_checker
#(
   parameter int SWITCH_WIDTH = 8
)
(
   input logic                    clock,
   input logic                    reset,
   input logic                    rsp_valid,
   input logic                    rsp_ready,
   input logic                    rsp_power_write,
   input logic                    rsp_power_level,
   input logic                    rsp_status_write,
   input logic                    rsp_status_level,
   input logic                    rsp_region_changed,
   input logic [SWITCH_WIDTH-1:0] rsp_region_value,
   input logic                    rsp_laser_alarm_write
);

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_power_level)
         && $stable(rsp_status_level) && $stable(rsp_region_value))
      else $error("rsp item changed while stalled");

   a_reset_empty: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("rsp_valid high after reset");

   a_power_idle: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_power_level |-> rsp_power_write)
      else $error("power level without write");

   a_status_alarm: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_status_write |-> rsp_laser_alarm_write)
      else $error("status write without laser alarm write");

   a_value_idle: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_region_changed |-> rsp_region_value == '0)
      else $error("region value without change pulse");

endmodule

bind alarm_led_blink_controller_top alb_checker #(
   .SWITCH_WIDTH (SWITCH_WIDTH)
) u_alb_checker (.*);

### tb/sv/alarm_led_blink_controller_top_tb.sv
// Testbench for alarm_led_blink_controller_top: random and directed timer ticks,
// a tick-exact blink/sampling predictor inside a small scoreboard class.
// Depends on alb_pkg and the top-level RTL only.
`timescale 1ns / 1ps

module alarm_led_blink_controller_top_tb;
   import alb_pkg::*;

   localparam int SW_BITS     = 8;
   localparam int MAX_REPORTS = 10;
   localparam int IDLE_PCT    = 9;
   localparam int LIMIT_NS    = 2_000_000;
   localparam int ALARM_BITS  = $bits(alarm_type);

   typedef struct packed {
      alarm_type          alarms;
      logic [SW_BITS-1:0] switch_sample;
   } tick_type;

   typedef struct packed {
      logic               power_write;
      logic               power_level;
      logic               status_write;
      logic               status_level;
      logic               region_changed;
      logic [SW_BITS-1:0] region_value;
      logic               laser_alarm_write;
   } led_result_type;

   class blink_scoreboard;
      cfg_type                terminals;
      logic [COUNT_WIDTH-1:0] blink_count [NUM_FLAGS];
      logic [COUNT_WIDTH-1:0] sample_count;
      logic [NUM_FLAGS-1:0]   blink_flags;
      logic                   power_on;
      logic                   status_on;
      logic [SW_BITS-1:0]     last_sample;
      led_result_type         led_q [$];
      int                     ticks;
      int                     checked;
      int                     failures;
      int                     writes;

      function new();
         terminals.short_terminal  = SHORT_TERMINAL_RESET;
         terminals.mid_terminal    = MID_TERMINAL_RESET;
         terminals.long_terminal   = LONG_TERMINAL_RESET;
         terminals.sample_terminal = SAMPLE_TERMINAL_RESET;
         foreach (blink_count[f]) blink_count[f] = '0;
         sample_count = '0;
         blink_flags  = '0;
         power_on     = 1'b0;
         status_on    = 1'b0;
         last_sample  = '0;
      endfunction

      function void note_config(logic [CSR_INDEX_WIDTH-1:0] idx,
                                logic [CSR_DATA_WIDTH-1:0] data);
         writes++;
         case (idx)
            REG_SHORT_TERMINAL:  terminals.short_terminal  = data;
            REG_MID_TERMINAL:    terminals.mid_terminal    = data;
            REG_LONG_TERMINAL:   terminals.long_terminal   = data;
            REG_SAMPLE_TERMINAL: terminals.sample_terminal = data;
            default: ;
         endcase
      endfunction

      function logic [COUNT_WIDTH-1:0] flag_terminal(int f);
         case (f)
            FLAG_ST_MID, FLAG_PW_MID:     return terminals.mid_terminal;
            FLAG_ST_SHORT, FLAG_PW_SHORT: return terminals.short_terminal;
            default:                      return terminals.long_terminal;
         endcase
      endfunction

      function bit take_flag(int f);
         if (blink_flags[f]) begin
            blink_flags[f] = 1'b0;
            return 1'b1;
         end
         return 1'b0;
      endfunction

      function void note_tick(tick_type t);
         led_result_type r;
         bit             hit;
         r = '0;
         ticks++;
         for (int f = 0; f < NUM_FLAGS; f++) begin
            if (blink_count[f] == flag_terminal(f)) begin
               blink_count[f] = '0;
               blink_flags[f] = 1'b1;
            end else begin
               blink_count[f] = blink_count[f] + 1'b1;
            end
         end
         if (sample_count == terminals.sample_terminal) begin
            sample_count = '0;
            if (t.switch_sample != last_sample) begin
               r.region_changed = 1'b1;
               r.region_value   = t.switch_sample;
            end
            last_sample = t.switch_sample;
         end else begin
            sample_count = sample_count + 1'b1;
         end
         if (t.alarms.zone_alarm != '0) begin
            if (t.alarms.zone_alarm[REGION_FAST]) hit = take_flag(FLAG_PW_SHORT);
            else if (t.alarms.zone_alarm[REGION_MID]) hit = take_flag(FLAG_PW_MID);
            else hit = take_flag(FLAG_PW_LONG);
            if (hit) begin
               power_on      = ~power_on;
               r.power_write = 1'b1;
               r.power_level = power_on;
            end
         end else begin
            r.power_write = 1'b1;
            r.power_level = 1'b1;
         end
         if (t.alarms.motor_slow || t.alarms.laser_dead) begin
            r.status_write      = 1'b1;
            r.status_level      = 1'b1;
            r.laser_alarm_write = 1'b1;
         end else if (t.alarms.window_dirty || t.alarms.over_temp) begin
            hit = t.alarms.window_dirty ? take_flag(FLAG_ST_MID) : take_flag(FLAG_ST_SHORT);
            if (hit) begin
               status_on      = ~status_on;
               r.status_write = 1'b1;
               r.status_level = status_on;
            end
            r.laser_alarm_write = 1'b1;
         end
         led_q.push_back(r);
      endfunction

      function string show(led_result_type r);
         return $sformatf("pw %b/%b st %b/%b chg %b val %h laser %b",
                          r.power_write, r.power_level, r.status_write, r.status_level,
                          r.region_changed, r.region_value, r.laser_alarm_write);
      endfunction

      function void check_result(led_result_type got);
         led_result_type want;
         if (led_q.size() == 0) begin
            failures++;
            if (failures <= MAX_REPORTS)
               $display("ERROR %0t: result with no tick pending: %s", $time, show(got));
            return;
         end
         want = led_q.pop_front();
         checked++;
         if (got !== want) begin
            failures++;
            if (failures <= MAX_REPORTS)
               $display("ERROR %0t: result %0d expected %s, got %s",
                        $time, checked, show(want), show(got));
         end
      endfunction

      function int pending();
         return led_q.size();
      endfunction
   endclass

   logic                       clock = 1'b0;
   logic                       reset = 1'b1;
   logic                       csr_valid = 1'b0;
   logic                       csr_ready;
   logic [CSR_INDEX_WIDTH-1:0] csr_index = '0;
   logic [CSR_DATA_WIDTH-1:0]  csr_data = '0;
   logic                       req_valid = 1'b0;
   logic                       req_ready;
   logic [2:0]                 req_zone_alarm = '0;
   logic                       req_motor_slow = 1'b0;
   logic                       req_laser_dead = 1'b0;
   logic                       req_over_temp = 1'b0;
   logic                       req_window_dirty = 1'b0;
   logic [SW_BITS-1:0]         req_switch_sample = '0;
   logic                       rsp_valid;
   logic                       rsp_ready = 1'b0;
   logic                       rsp_power_write;
   logic                       rsp_power_level;
   logic                       rsp_status_write;
   logic                       rsp_status_level;
   logic                       rsp_region_changed;
   logic [SW_BITS-1:0]         rsp_region_value;
   logic                       rsp_laser_alarm_write;

   blink_scoreboard sb = new();
   bit              steady = 1'b0;
   int              settings = 1;
   tick_type        scene = '0;
   int              scene_left = 0;

   alarm_led_blink_controller_top #(.SWITCH_WIDTH(SW_BITS)) dut (.*);

   always #5 clock = ~clock;

   always @(negedge clock) begin
      rsp_ready <= steady || ($urandom_range(99) >= IDLE_PCT);
   end

   always @(posedge clock) begin
      led_result_type seen;
      if (!reset && rsp_valid && rsp_ready) begin
         seen.power_write       = rsp_power_write;
         seen.power_level       = rsp_power_level;
         seen.status_write      = rsp_status_write;
         seen.status_level      = rsp_status_level;
         seen.region_changed    = rsp_region_changed;
         seen.region_value      = rsp_region_value;
         seen.laser_alarm_write = rsp_laser_alarm_write;
         sb.check_result(seen);
      end
   end

   function automatic tick_type mk_tick(logic [2:0] region, logic motor, logic laser,
                                        logic temp, logic dust, logic [SW_BITS-1:0] sw);
      tick_type t;
      t.alarms.zone_alarm   = region;
      t.alarms.motor_slow   = motor;
      t.alarms.laser_dead   = laser;
      t.alarms.over_temp    = temp;
      t.alarms.window_dirty = dust;
      t.switch_sample       = sw;
      return t;
   endfunction

   // Mostly held alarm patterns so the blink flags get consumed, plus noise.
   function automatic tick_type random_tick();
      tick_type t;
      if ($urandom_range(99) < 15) begin
         t.alarms        = alarm_type'(ALARM_BITS'($urandom));
         t.switch_sample = SW_BITS'($urandom);
         return t;
      end
      if (scene_left == 0) begin
         scene.alarms.zone_alarm   = 3'($urandom_range(0, 7));
         scene.alarms.motor_slow   = ($urandom_range(99) < 15);
         scene.alarms.laser_dead   = ($urandom_range(99) < 15);
         scene.alarms.over_temp    = ($urandom_range(99) < 35);
         scene.alarms.window_dirty = ($urandom_range(99) < 35);
         scene_left = $urandom_range(1, 60);
      end
      scene_left--;
      if ($urandom_range(99) < 10) scene.switch_sample = SW_BITS'($urandom);
      return scene;
   endfunction

   task automatic send_tick(tick_type t);
      @(negedge clock);
      while (!steady && $urandom_range(99) < IDLE_PCT) begin
         req_valid <= 1'b0;
         @(negedge clock);
      end
      req_valid         <= 1'b1;
      req_zone_alarm    <= t.alarms.zone_alarm;
      req_motor_slow    <= t.alarms.motor_slow;
      req_laser_dead    <= t.alarms.laser_dead;
      req_over_temp     <= t.alarms.over_temp;
      req_window_dirty  <= t.alarms.window_dirty;
      req_switch_sample <= t.switch_sample;
      do @(posedge clock); while (!req_ready);
      sb.note_tick(t);
   endtask

   task automatic run_phase(int count);
      for (int i = 0; i < count; i++) send_tick(random_tick());
      @(negedge clock);
      req_valid <= 1'b0;
   endtask

   task automatic drain();
      while (sb.pending() != 0) @(posedge clock);
   endtask

   task automatic write_reg(logic [CSR_INDEX_WIDTH-1:0] idx, logic [CSR_DATA_WIDTH-1:0] data);
      @(negedge clock);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data  <= data;
      do @(posedge clock); while (!csr_ready);
      sb.note_config(idx, data);
      @(negedge clock);
      csr_valid <= 1'b0;
   endtask

   task automatic set_terminals(logic [7:0] fast, logic [7:0] mid, logic [7:0] slow,
                                logic [7:0] sample);
      drain();
      write_reg(REG_SHORT_TERMINAL, fast);
      write_reg(REG_MID_TERMINAL, mid);
      write_reg(REG_LONG_TERMINAL, slow);
      write_reg(REG_SAMPLE_TERMINAL, sample);
      settings++;
   endtask

   initial begin
      tick_type directed [$];
      repeat (8) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // reset terminals: switch samples land on every fourth tick
      directed.push_back(mk_tick(3'd0, 1'b0, 1'b0, 1'b0, 1'b0, 8'h00));
      directed.push_back(mk_tick(3'd1, 1'b0, 1'b0, 1'b0, 1'b0, 8'hFF));
      directed.push_back(mk_tick(3'd2, 1'b1, 1'b0, 1'b0, 1'b0, 8'hFF));
      directed.push_back(mk_tick(3'd4, 1'b0, 1'b1, 1'b0, 1'b0, 8'hFF));
      directed.push_back(mk_tick(3'd3, 1'b0, 1'b0, 1'b1, 1'b0, 8'h55));
      directed.push_back(mk_tick(3'd5, 1'b0, 1'b0, 1'b0, 1'b1, 8'h55));
      directed.push_back(mk_tick(3'd6, 1'b0, 1'b0, 1'b1, 1'b1, 8'hAA));
      directed.push_back(mk_tick(3'd7, 1'b1, 1'b1, 1'b1, 1'b1, 8'hFF));
      for (int i = 0; i < 8; i++) directed.push_back(mk_tick(3'd1, 1'b0, 1'b0, 1'b1, 1'b0, 8'h00));
      for (int i = 0; i < 4; i++) directed.push_back(mk_tick(3'd7, 1'b0, 1'b0, 1'b0, 1'b1, 8'h80));
      for (int i = 0; i < 4; i++) directed.push_back(mk_tick(3'd0, 1'b0, 1'b0, 1'b1, 1'b1, 8'h01));
      foreach (directed[i]) send_tick(directed[i]);
      @(negedge clock);
      req_valid <= 1'b0;

      run_phase(220);
      set_terminals(8'd0, 8'd0, 8'd0, 8'd0);
      run_phase(100);
      steady = 1'b1;
      set_terminals(8'd255, 8'd255, 8'd255, 8'd255);
      run_phase(160);
      steady = 1'b0;
      // terminals drop below the running counts, which then wrap round
      set_terminals(8'd4, 8'd9, 8'd2, 8'd1);
      run_phase(200);
      drain();
      write_reg(CSR_INDEX_WIDTH'($urandom_range(4, 255)), CSR_DATA_WIDTH'($urandom));
      for (int p = 0; p < 3; p++) begin
         set_terminals(8'($urandom_range(0, 24)), 8'($urandom_range(0, 24)),
                       8'($urandom_range(0, 24)), 8'($urandom_range(0, 24)));
         run_phase(100);
      end
      set_terminals(8'd0, 8'd255, 8'd1, 8'd255);
      run_phase(80);

      drain();
      repeat (4) @(posedge clock);
      $display("Run covered %0d ticks, %0d register writes and %0d terminal settings;",
               sb.ticks, sb.writes, settings);
      $display("%0d results checked, %0d mismatches.", sb.checked, sb.failures);
      if (sb.failures == 0 && sb.pending() == 0) begin
         $display("Verification passed");
      end else begin
         $display("Verification failed");
      end
      $finish;
   end

   initial begin
      #(LIMIT_NS);
      $display("Timeout with %0d results outstanding", sb.pending());
      $display("Verification failed");
      $finish;
   end

endmodule
